[sv/rmsm_pkg.sv]
// shared types and constants of the dual channel sliding rms meter
// no dependencies; imported by rmsm_chan and the top level
`timescale 1ns / 1ps

package rmsm_pkg;

  // default ring depth of one channel
  localparam int WINDOW_DEFAULT = 256;

  // significant bits of an adc code; wider codes are masked
  localparam int ADC_BITS = 12;

  // field widths
  localparam int CODE_W      = 12;
  localparam int SCALE_W     = 16;
  localparam int RMS_W       = 16;
  localparam int SQ_W        = 31;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indices of the config port
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_BIAS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_BIAS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_SCALE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_SCALE  = 3'd5;

  // mask applied to codes and bias codes
  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << ADC_BITS) - 64'd1);

  // saturation limits of the scaled magnitude
  localparam logic [RMS_W-1:0] SAT_POS = 16'd32767;
  localparam logic [RMS_W-1:0] SAT_NEG = 16'd32768;

  // register reset values
  localparam logic [CODE_W-1:0]  BIAS_RESET  = 12'd2048;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // input word
  typedef struct packed {
    logic [CODE_W-1:0] current_code;
    logic [CODE_W-1:0] voltage_code;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [RMS_W-1:0] current_level;
    logic             current_ready;
    logic [RMS_W-1:0] voltage_level;
    logic             voltage_ready;
  } out_word_t;

  // control from the top level to one channel
  typedef struct packed {
    logic start;
    logic ack;
    logic restart;
  } chan_ctrl_t;

  // status and result of one channel
  typedef struct packed {
    logic             done;
    logic [RMS_W-1:0] rms;
    logic             rdy;
  } chan_res_t;

endpackage

[sv/rmsm_ram.sv]
// generic single clock ram with one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rmsm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/rmsm_chan.sv]
// one channel: scaling, squaring, ring update and root of the window mean
// depends on rmsm_pkg and rmsm_ram
`timescale 1ns / 1ps

module rmsm_chan import rmsm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  chan_ctrl_t         ctrl,
  input  logic               en,
  input  logic [CODE_W-1:0]  code,
  input  logic [CODE_W-1:0]  bias,
  input  logic [SCALE_W-1:0] scale,
  output chan_res_t          res
);

  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW + 1) + 30;
  localparam int RT_W   = SUM_W + 2;
  localparam int PROD_W = CODE_W + SCALE_W;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [RMS_W-1:0]  ROOT_BIT0 = RMS_W'(1) << (RMS_W - 1);
  localparam logic [RT_W-1:0]   QUAD0     = RT_W'(WINDOW) << (2 * (RMS_W - 1));

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SQR  = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]  pos;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  sum;

  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [RMS_W-1:0]  mag;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   old_sq;

  logic [RT_W-1:0]   racc;
  logic [RT_W-1:0]   rlin;
  logic [RT_W-1:0]   rquad;
  logic [RMS_W-1:0]  rres;
  logic [RMS_W-1:0]  rbit;

  logic [RMS_W-1:0]  rms;
  logic              rdy;

  // difference of masked code and bias
  logic [CODE_W-1:0] code_m, bias_m, diff;
  logic              diff_neg;

  always_comb begin
    code_m   = code & CODE_MASK;
    bias_m   = bias & CODE_MASK;
    diff_neg = code_m < bias_m;
    diff     = diff_neg ? (bias_m - code_m) : (code_m - bias_m);
  end

  // saturation of the q8.8 product
  logic [PROD_W-9:0] shifted;
  logic [RMS_W-1:0]  lim;
  logic [RMS_W-1:0]  mag_sat;

  always_comb begin
    shifted = prod[PROD_W-1:8];
    lim     = neg ? SAT_NEG : SAT_POS;
    mag_sat = (shifted > (PROD_W-8)'(lim)) ? lim : shifted[RMS_W-1:0];
  end

  // ring entry leaving the window; zero while still filling
  logic [SQ_W-1:0]   ram_rdata;
  logic [SUM_W-1:0]  sum_upd;
  logic [FILL_W-1:0] fill_upd;

  always_comb begin
    old_sq   = (fill == FILL_FULL) ? ram_rdata : '0;
    sum_upd  = sum - SUM_W'(old_sq) + SUM_W'(sq);
    fill_upd = (fill == FILL_FULL) ? fill : fill + FILL_W'(1);
  end

  // one bit of the root: the largest r with WINDOW * r * r <= sum is the root of the
  // floored mean; racc holds WINDOW * r * r, rlin WINDOW * r * 2^(b+1), rquad WINDOW * 4^b
  logic [RT_W-1:0] rtrial;
  logic            rfit;

  always_comb begin
    rtrial = racc + rlin + rquad;
    rfit   = (rtrial <= RT_W'(sum));
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (ctrl.start) state_next = en ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = ST_SQR;
      ST_SQR:  state_next = ST_UPD;
      ST_UPD:  state_next = (fill_upd == FILL_FULL) ? ST_ROOT : ST_DONE;
      ST_ROOT: if (rbit[0]) state_next = ST_DONE;
      ST_DONE: if (ctrl.ack) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (ctrl.restart) begin
      pos  <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (state == ST_UPD) begin
      pos  <= (pos == POS_LAST) ? '0 : pos + POS_W'(1);
      fill <= fill_upd;
      sum  <= sum_upd;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        neg  <= diff_neg;
        prod <= PROD_W'(diff) * PROD_W'(scale);
        rms  <= '0;
        rdy  <= 1'b0;
      end
      ST_MUL: begin
        mag <= mag_sat;
      end
      ST_SQR: begin
        sq <= SQ_W'(mag) * SQ_W'(mag);
      end
      ST_UPD: begin
        racc  <= '0;
        rlin  <= '0;
        rquad <= QUAD0;
        rres  <= '0;
        rbit  <= ROOT_BIT0;
      end
      ST_ROOT: begin
        if (rfit) begin
          racc <= rtrial;
          rlin <= (rlin >> 1) + rquad;
          rres <= rres | rbit;
        end else begin
          rlin <= rlin >> 1;
        end
        rquad <= rquad >> 2;
        rbit  <= rbit >> 1;
        if (rbit[0]) begin
          rms <= rfit ? (rres | rbit) : rres;
          rdy <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ring of squares
  rmsm_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPD),
    .waddr (pos),
    .wdata (sq),
    .re    (ctrl.start),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign res = '{done: (state == ST_DONE), rms: rms, rdy: rdy};

  // fill count saturates at the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count beyond window");

  // the root is only taken over a full window
  a_root_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (fill == FILL_FULL))
    else $error("root taken before window full");

  // a new word only starts an idle channel
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> (state == ST_IDLE))
    else $error("start while channel busy");

endmodule

[sv/dual_channel_sliding_rms_meter.sv]
// Dual channel sliding rms meter. Each input word carries one current and one voltage adc
// code; each enabled channel removes its bias, applies its q8.8 gain with 16-bit signed
// saturation, squares, and keeps the squares in a WINDOW-deep ring (one ram per channel)
// with a running sum. Every accepted word gives exactly one output word; a channel reports
// floor(sqrt(sum / WINDOW)) with its ready flag once the ring is full, and 0 otherwise.
// Both channels run side by side. A channel with a full window passes each accepted word
// through registered scaling, saturation, squaring and ring update, then a 16-bit square
// root at one result bit per cycle (the division by WINDOW is folded into the trial compare
// against the sum), and then into the output register; a filling channel skips the root
// and a disabled channel goes straight to its zero result. The next word is accepted once
// the result moves into the output register, even if that output word has not yet been
// taken; only one word is in flight at a time, and a result waits while the receiver stalls.
// Writing an enable register restarts that channel's window through its fill count, so
// the rings need no clearing pass after reset. Config port indices: 0/1 current/voltage
// enable, 2/3 bias codes, 4/5 scales; other indices ignored.
// depends on rmsm_pkg, rmsm_chan and rmsm_ram
`timescale 1ns / 1ps

module dual_channel_sliding_rms_meter import rmsm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic               current_enable;
  logic               voltage_enable;
  logic [CODE_W-1:0]  current_bias_code;
  logic [CODE_W-1:0]  voltage_bias_code;
  logic [SCALE_W-1:0] current_scale;
  logic [SCALE_W-1:0] voltage_scale;

  logic      busy;
  logic      start;
  logic      load;
  logic      cfg_we;
  chan_res_t cur_res;
  chan_res_t volt_res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_enable    <= 1'b0;
      voltage_enable    <= 1'b0;
      current_bias_code <= BIAS_RESET;
      voltage_bias_code <= BIAS_RESET;
      current_scale     <= SCALE_RESET;
      voltage_scale     <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURRENT_ENABLE: current_enable    <= cfg_data[0];
        CFG_VOLTAGE_ENABLE: voltage_enable    <= cfg_data[0];
        CFG_CURRENT_BIAS:   current_bias_code <= cfg_data[CODE_W-1:0];
        CFG_VOLTAGE_BIAS:   voltage_bias_code <= cfg_data[CODE_W-1:0];
        CFG_CURRENT_SCALE:  current_scale     <= cfg_data;
        CFG_VOLTAGE_SCALE:  voltage_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  // one word in flight at a time
  assign in_ready = ~busy;
  assign start    = in_valid & in_ready;
  assign load     = cur_res.done & volt_res.done & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= '{current_level: cur_res.rms,
                    current_ready: cur_res.rdy,
                    voltage_level: volt_res.rms,
                    voltage_ready: volt_res.rdy};
    end
  end

  // channels
  rmsm_chan #(
    .WINDOW (WINDOW)
  ) u_current (
    .clk   (clk),
    .rst   (rst),
    .ctrl  ('{start: start, ack: load,
              restart: cfg_we && (cfg_index == CFG_CURRENT_ENABLE)}),
    .en    (current_enable),
    .code  (in_data.current_code),
    .bias  (current_bias_code),
    .scale (current_scale),
    .res   (cur_res)
  );

  rmsm_chan #(
    .WINDOW (WINDOW)
  ) u_voltage (
    .clk   (clk),
    .rst   (rst),
    .ctrl  ('{start: start, ack: load,
              restart: cfg_we && (cfg_index == CFG_VOLTAGE_ENABLE)}),
    .en    (voltage_enable),
    .code  (in_data.voltage_code),
    .bias  (voltage_bias_code),
    .scale (voltage_scale),
    .res   (volt_res)
  );

endmodule
